FILE: sv/rnv_pkg.sv
// ----------------------------------------------------------------------------
// rnv_pkg
// Shared constants and types for the rotate-and-normalise pipeline.
// ----------------------------------------------------------------------------
package rnv_pkg;

  // Width of every vector and matrix field
  localparam int DATA_W = 16;

  // Default fraction bits (Q1.14)
  localparam int FRAC_BITS_DEF = 14;

  // Bits of |sum of three 16x16 products| (below 2^32)
  localparam int SUM_MAG_W = 32;

  // Per-item flags carried down the pipe beside the data
  typedef struct packed {
    logic [2:0] neg;   // component sign, x in bit 0
    logic       zero;  // squared length was zero
  } rnv_side_t;

endpackage

FILE: sv/rotate_normalize_vector3.sv
// ----------------------------------------------------------------------------
// rotate_normalize_vector3
// Row vector times 3x3 matrix, then divide by the integer Euclidean length.
// Pipeline: products, column sums, squares, squared length, then the sqrt pipe
//   (one stage per root bit), divider (one per quotient bit) and output register.
// Throughput: one request per cycle; busy is always low.
// Results appear on done for one cycle and cannot be stalled.
// Reset (rst, synchronous) clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
module rotate_normalize_vector3 #(
  parameter int FRAC_BITS = rnv_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [rnv_pkg::DATA_W-1:0] dir_x,
  input  logic signed [rnv_pkg::DATA_W-1:0] dir_y,
  input  logic signed [rnv_pkg::DATA_W-1:0] dir_z,
  input  logic signed [rnv_pkg::DATA_W-1:0] rot_00,
  input  logic signed [rnv_pkg::DATA_W-1:0] rot_01,
  input  logic signed [rnv_pkg::DATA_W-1:0] rot_02,
  input  logic signed [rnv_pkg::DATA_W-1:0] rot_10,
  input  logic signed [rnv_pkg::DATA_W-1:0] rot_11,
  input  logic signed [rnv_pkg::DATA_W-1:0] rot_12,
  input  logic signed [rnv_pkg::DATA_W-1:0] rot_20,
  input  logic signed [rnv_pkg::DATA_W-1:0] rot_21,
  input  logic signed [rnv_pkg::DATA_W-1:0] rot_22,
  output logic                              done,
  output logic signed [rnv_pkg::DATA_W-1:0] out_x,
  output logic signed [rnv_pkg::DATA_W-1:0] out_y,
  output logic signed [rnv_pkg::DATA_W-1:0] out_z,
  output logic                              zero_length
);

  localparam int DW = rnv_pkg::DATA_W;
  localparam int PW = 2 * DW;              // one product
  localparam int AW = PW + 2;              // sum of three products
  localparam int MW = rnv_pkg::SUM_MAG_W - FRAC_BITS;
  localparam int SW = 66 - 2 * FRAC_BITS;
  localparam int LW = 33 - FRAC_BITS;
  localparam int QW = FRAC_BITS + 1;

  assign busy = 1'b0;

  // Stage 1: nine products
  logic                 v1;
  logic signed [PW-1:0] prod [3][3];
  logic signed [DW-1:0] vin  [3];
  logic signed [DW-1:0] min  [3][3];

  assign vin[0] = dir_x;
  assign vin[1] = dir_y;
  assign vin[2] = dir_z;
  assign min[0] = '{rot_00, rot_01, rot_02};
  assign min[1] = '{rot_10, rot_11, rot_12};
  assign min[2] = '{rot_20, rot_21, rot_22};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[i][j] <= vin[i] * min[i][j];
      end
    end
  end

  // Stage 2: column sums, shift toward zero
  logic          v2;
  logic [MW-1:0] mag2 [3];
  logic [2:0]    neg2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_col
    logic signed [AW-1:0] col;
    logic [AW-1:0]        col_abs;

    assign col = AW'(prod[0][j]) + AW'(prod[1][j]) + AW'(prod[2][j]);
    assign col_abs = col[AW-1] ? AW'(-col) : AW'(col);

    always_ff @(posedge clk) begin
      mag2[j] <= MW'(col_abs >> FRAC_BITS);
      neg2[j] <= col[AW-1];
    end
  end

  // Stage 3: squares
  logic            v3;
  logic [2*MW-1:0] sq3  [3];
  logic [MW-1:0]   mag3 [3];
  logic [2:0]      neg3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      sq3[j] <= mag2[j] * mag2[j];
    end
    mag3 <= mag2;
    neg3 <= neg2;
  end

  // Stage 4: squared length and zero flag
  logic               v4;
  logic [SW-1:0]      sum4;
  logic [MW-1:0]      mag4 [3];
  rnv_pkg::rnv_side_t side4;
  logic [SW-1:0]      sum3;

  assign sum3 = SW'(sq3[0]) + SW'(sq3[1]) + SW'(sq3[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    sum4       <= sum3;
    mag4       <= mag3;
    side4.neg  <= neg3;
    side4.zero <= (sum3 == '0);
  end

  // Length
  logic               vs;
  logic [LW-1:0]      len_s;
  logic [MW-1:0]      mag_s [3];
  rnv_pkg::rnv_side_t side_s;

  rnv_isqrt #(.FRAC_BITS(FRAC_BITS)) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .sq_sum    (sum4),
    .mag_in    (mag4),
    .side_in   (side4),
    .out_valid (vs),
    .root      (len_s),
    .mag_out   (mag_s),
    .side_out  (side_s)
  );

  // Normalise
  logic               vd;
  logic [QW-1:0]      quot_d [3];
  rnv_pkg::rnv_side_t side_d;

  rnv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vs),
    .len       (len_s),
    .mag_in    (mag_s),
    .side_in   (side_s),
    .out_valid (vd),
    .quot      (quot_d),
    .side_out  (side_d)
  );

  // Output stage: saturate, sign, zero pass-through
  logic [DW-1:0] res [3];

  for (genvar j = 0; j < 3; j++) begin : g_out
    logic [QW-1:0]      qs;
    logic signed [QW:0] sgn;

    assign qs  = (quot_d[j] > (QW'(1) << FRAC_BITS)) ? (QW'(1) << FRAC_BITS)
                                                      : quot_d[j];
    assign sgn = side_d.neg[j] ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
    assign res[j] = side_d.zero ? '0 : DW'(sgn);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd;
    end
  end

  always_ff @(posedge clk) begin
    out_x       <= res[0];
    out_y       <= res[1];
    out_z       <= res[2];
    zero_length <= side_d.zero;
  end

  // zero length always comes out as a null vector
  a_zero_null: assert property (@(posedge clk) disable iff (rst)
    (done && zero_length) |-> (out_x == '0 && out_y == '0 && out_z == '0))
    else $error("zero-length result not null");

  // a result follows its divider output in the next cycle
  a_done_follow: assert property (@(posedge clk) disable iff (rst)
    vd |=> done)
    else $error("result strobe lost");

  // requests are never refused
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

endmodule

FILE: sv/rnv_isqrt.sv
// ----------------------------------------------------------------------------
// rnv_isqrt
// Pipelined integer square root, one root bit per stage (remainder method).
// Component magnitudes and flags ride along with the root.
// ----------------------------------------------------------------------------
module rnv_isqrt #(
  parameter int FRAC_BITS = rnv_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [65-2*FRAC_BITS:0] sq_sum,
  input  logic [31-FRAC_BITS:0]   mag_in [3],
  input  rnv_pkg::rnv_side_t      side_in,
  output logic                    out_valid,
  output logic [32-FRAC_BITS:0]   root,
  output logic [31-FRAC_BITS:0]   mag_out [3],
  output rnv_pkg::rnv_side_t      side_out
);

  localparam int MW = rnv_pkg::SUM_MAG_W - FRAC_BITS;
  localparam int SW = 66 - 2 * FRAC_BITS;
  localparam int LW = 33 - FRAC_BITS;
  localparam int TW = SW + 1;

  logic               vld  [LW+1];
  logic [SW-1:0]      rem  [LW+1];
  logic [LW-1:0]      rt   [LW+1];
  logic [MW-1:0]      mag  [LW+1][3];
  rnv_pkg::rnv_side_t side [LW+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = sq_sum;
  assign rt[0]   = '0;
  assign mag[0]  = mag_in;
  assign side[0] = side_in;

  // One stage per root bit, most significant first
  for (genvar k = 0; k < LW; k++) begin : g_stage
    localparam int B = LW - 1 - k;
    logic [TW-1:0] trial;
    logic          take;

    assign trial = (TW'(rt[k]) << (B + 1)) + (TW'(1) << (2 * B));
    assign take  = ({1'b0, rem[k]} >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1]  <= take ? (rem[k] - trial[SW-1:0]) : rem[k];
      rt[k+1]   <= take ? (rt[k] | (LW'(1) << B)) : rt[k];
      mag[k+1]  <= mag[k];
      side[k+1] <= side[k];
    end
  end

  assign out_valid = vld[LW];
  assign root      = rt[LW];
  assign mag_out   = mag[LW];
  assign side_out  = side[LW];

  // root is the floor of the square root of its operand
  logic [SW-1:0] sum_dly [LW+1];
  assign sum_dly[0] = sq_sum;
  for (genvar k = 0; k < LW; k++) begin : g_chk
    always_ff @(posedge clk) begin
      sum_dly[k+1] <= sum_dly[k];
    end
  end

  a_root_low: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((2*LW)'(root) * (2*LW)'(root) <= (2*LW)'(sum_dly[LW])))
    else $error("isqrt root too large");

  a_root_high: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (((2*LW+2)'(root) + 1) * ((2*LW+2)'(root) + 1)
                   > (2*LW+2)'(sum_dly[LW])))
    else $error("isqrt root too small");

endmodule

FILE: sv/rnv_div.sv
// ----------------------------------------------------------------------------
// rnv_div
// Three-lane pipelined restoring divider: q = (mag << FRAC_BITS) / len.
// One quotient bit per stage; mag never exceeds len, so q needs FRAC_BITS+1.
// ----------------------------------------------------------------------------
module rnv_div #(
  parameter int FRAC_BITS = rnv_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [32-FRAC_BITS:0] len,
  input  logic [31-FRAC_BITS:0] mag_in [3],
  input  rnv_pkg::rnv_side_t    side_in,
  output logic                  out_valid,
  output logic [FRAC_BITS:0]    quot [3],
  output rnv_pkg::rnv_side_t    side_out
);

  localparam int LW = 33 - FRAC_BITS;
  localparam int QW = FRAC_BITS + 1;
  localparam int DS = FRAC_BITS + 1;

  logic               vld  [DS+1];
  logic [LW-1:0]      dvs  [DS+1];
  logic [LW-1:0]      rem  [DS+1][3];
  logic [QW-1:0]      q    [DS+1][3];
  rnv_pkg::rnv_side_t side [DS+1];

  assign vld[0]  = in_valid;
  assign dvs[0]  = len;
  assign side[0] = side_in;
  for (genvar j = 0; j < 3; j++) begin : g_in
    assign rem[0][j] = LW'(mag_in[j]);
    assign q[0][j]   = '0;
  end

  for (genvar k = 0; k < DS; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      dvs[k+1]  <= dvs[k];
      side[k+1] <= side[k];
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [LW:0] part;
      logic        bit_q;

      // integer step first, then one fraction bit per stage
      if (k == 0) begin : g_first
        assign part = {1'b0, rem[k][j]};
      end else begin : g_frac
        assign part = {rem[k][j], 1'b0};
      end
      assign bit_q = (part >= {1'b0, dvs[k]});

      always_ff @(posedge clk) begin
        rem[k+1][j] <= bit_q ? LW'(part - {1'b0, dvs[k]}) : LW'(part);
        q[k+1][j]   <= {q[k][j][QW-2:0], bit_q};
      end
    end
  end

  assign out_valid = vld[DS];
  assign quot      = q[DS];
  assign side_out  = side[DS];

  // the quotient never passes 1.0 for a non-zero length
  for (genvar j = 0; j < 3; j++) begin : g_chk
    a_quot_max: assert property (@(posedge clk) disable iff (rst)
      (out_valid && !side_out.zero) |-> (quot[j] <= (QW'(1) << FRAC_BITS)))
      else $error("quotient above one");
  end

endmodule
